// File: design/su2_link_product_accumulator_core_defines.svh
// ---------------------------------------------------------------------------
// SU(2) link product accumulator: shared assertion macros
// Concurrent property wrappers used by the accumulator RTL.
// ---------------------------------------------------------------------------
`ifndef SU2_LINK_PRODUCT_ACCUMULATOR_CORE_DEFINES_SVH
`define SU2_LINK_PRODUCT_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SU2LPA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SU2LPA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/su2lpa_pkg.sv
// ---------------------------------------------------------------------------
// SU(2) link product accumulator package
// Payload types, widths, multiply-accumulate interface and saturation helpers.
// ---------------------------------------------------------------------------
package su2lpa_pkg;

    localparam int COMP_W       = 24;
    localparam int SUM_W        = 32;
    localparam int MUL_W        = SUM_W + COMP_W;
    localparam int ACC_W        = MUL_W + 2;
    localparam int FRAC_BITS_DEF = 16;
    localparam int APB_ADDR_W   = 2;
    localparam int APB_DATA_W   = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_SUM_SCALE = '0;
    localparam logic signed [COMP_W-1:0] SUM_SCALE_RST = COMP_W'(65536);

    localparam logic signed [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam logic signed [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};

    // Term signs of the quaternion product, bit index {component, term}.
    localparam logic [15:0] QMUL_NEG = 16'h428E;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp0;
        logic signed [COMP_W-1:0] comp1;
        logic signed [COMP_W-1:0] comp2;
        logic signed [COMP_W-1:0] comp3;
        logic                     conjugate;
        logic                     end_term;
        logic                     end_sum;
    } in_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum0;
        logic signed [SUM_W-1:0] sum1;
        logic signed [SUM_W-1:0] sum2;
        logic signed [SUM_W-1:0] sum3;
        logic signed [SUM_W-1:0] trace_re;
    } out_item_t;

    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     last;
        logic                     neg;
        logic [1:0]               tag;
        logic signed [SUM_W-1:0]  a;
        logic signed [COMP_W-1:0] b;
    } mac_cmd_t;

    typedef struct packed {
        logic                    done;
        logic [1:0]              tag;
        logic signed [ACC_W-1:0] value;
    } mac_res_t;

    function automatic logic signed [COMP_W-1:0] sat_comp(input logic signed [ACC_W-1:0] x);
        logic signed [COMP_W-1:0] r;
        if (x > ACC_W'(COMP_MAX)) begin
            r = COMP_MAX;
        end else if (x < ACC_W'(COMP_MIN)) begin
            r = COMP_MIN;
        end else begin
            r = x[COMP_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] x);
        logic signed [SUM_W-1:0] r;
        if (x > ACC_W'(SUM_MAX)) begin
            r = SUM_MAX;
        end else if (x < ACC_W'(SUM_MIN)) begin
            r = SUM_MIN;
        end else begin
            r = x[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/su2lpa_mac.sv
// ---------------------------------------------------------------------------
// SU(2) link product accumulator: shared multiply-accumulate unit
// One signed multiplier, a product register and a rounding accumulator.
// ---------------------------------------------------------------------------
`include "su2_link_product_accumulator_core_defines.svh"

module su2lpa_mac #(
    parameter int FRAC_BITS = su2lpa_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  su2lpa_pkg::mac_cmd_t  cmd,
    output su2lpa_pkg::mac_res_t  res
);
    import su2lpa_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'd1 << (FRAC_BITS - 1));

    logic signed [MUL_W-1:0] prod_reg, prod_next;
    logic                    p_vld_reg, p_first_reg, p_last_reg, p_neg_reg;
    logic [1:0]              p_tag_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] term;
    logic                    done_reg;
    logic [1:0]              a_tag_reg;

    assign prod_next = MUL_W'(cmd.a) * MUL_W'(cmd.b);
    assign term      = p_neg_reg ? -ACC_W'(prod_reg) : ACC_W'(prod_reg);
    assign acc_next  = p_first_reg ? term : acc_reg + term;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            p_vld_reg <= cmd.valid;
            done_reg  <= p_vld_reg && p_last_reg;
        end
        // payload stages
        prod_reg    <= prod_next;
        p_first_reg <= cmd.first;
        p_last_reg  <= cmd.last;
        p_neg_reg   <= cmd.neg;
        p_tag_reg   <= cmd.tag;
        a_tag_reg   <= p_tag_reg;
        if (p_vld_reg) begin
            acc_reg <= acc_next;
        end
    end

    // round half up, then drop the fraction bits
    assign res.done  = done_reg;
    assign res.tag   = a_tag_reg;
    assign res.value = (acc_reg + HALF) >>> FRAC_BITS;

    `SU2LPA_ASSERT_NXT(a_done_after_last, aclk, aresetn, p_vld_reg && p_last_reg, done_reg, "mac: result strobe missing after last term")
    `SU2LPA_ASSERT_IMP(a_done_has_source, aclk, aresetn, done_reg, $past(p_vld_reg) && $past(p_last_reg), "mac: result strobe without last term")

endmodule

// File: design/su2_link_product_accumulator_core.sv
// ---------------------------------------------------------------------------
// SU(2) link product accumulator
// Right-multiplies SU(2) elements onto a running product, sums closed terms
// and emits the scaled sum with its real trace.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one element per transaction (four Q8.16 components plus the
//   conjugate, end_term and end_sum marks). s_ready is high only while the
//   block is idle; each transaction is worked on by one shared signed
//   multiplier under a small sequencer.
//   After a plain element is accepted s_ready stays low through 16
//   multiplier issues (four terms for each of four components), the
//   multiplier/accumulator drain and the commit step, so the next element
//   is taken only once the previous one is finished.
//   An end_sum element adds four scaling multiplies, a second drain and an
//   emit step: m_valid then rises with one m_* transaction carrying the four
//   scaled sum components and the trace, and the next element is taken
//   once the emit step is done.
//   m_* is a registered output: a finished result waits there while the next
//   element is already taken. Should an emit find the register still full,
//   the sequencer holds in its emit step until m_ready frees it.
//   sum_scale lives on the APB port at byte address 0; write it only while
//   idle. Reset (aresetn low, synchronous) sets the product to identity, the
//   sum to zero, sum_scale to 1.0 and drops m_valid.
// ---------------------------------------------------------------------------
`include "su2_link_product_accumulator_core_defines.svh"

module su2_link_product_accumulator_core #(
    parameter int FRAC_BITS = su2lpa_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // element input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  su2lpa_pkg::in_item_t                 s_data,
    // result output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output su2lpa_pkg::out_item_t                m_data,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [su2lpa_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [su2lpa_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [su2lpa_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                 pready
);
    import su2lpa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    localparam logic signed [COMP_W-1:0] IDENT = COMP_W'(64'd1 << FRAC_BITS);
    localparam logic [3:0] MUL_LAST   = 4'd15;
    localparam logic [3:0] SCALE_LAST = 4'd3;

    state_t                   state_reg, state_next;
    logic [3:0]               step_reg, step_next;
    logic                     scale_phase_reg, scale_phase_next;
    logic signed [COMP_W-1:0] q_reg [4];
    logic signed [COMP_W-1:0] q_next [4];
    logic                     end_term_reg, end_term_next;
    logic                     end_sum_reg, end_sum_next;
    logic signed [COMP_W-1:0] prod_reg [4];
    logic signed [COMP_W-1:0] prod_next [4];
    logic signed [SUM_W-1:0]  sum_reg [4];
    logic signed [SUM_W-1:0]  sum_next [4];
    logic signed [SUM_W-1:0]  res_reg [4];
    logic signed [SUM_W-1:0]  res_next [4];
    logic signed [COMP_W-1:0] scale_reg, scale_next;
    logic                     m_valid_reg, m_valid_next;
    out_item_t                m_data_reg, m_data_next;

    logic                     cfg_wr;
    logic [1:0]               comp_k, term_j;
    mac_cmd_t                 mac_cmd;
    mac_res_t                 mac_res;
    logic signed [COMP_W-1:0] in_comp [4];

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_SUM_SCALE);
    assign prdata = (paddr == ADDR_SUM_SCALE) ? APB_DATA_W'(scale_reg) : '0;

    // ---------------- handshake outputs ----------------
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign in_comp[0] = s_data.comp0;
    assign in_comp[1] = s_data.comp1;
    assign in_comp[2] = s_data.comp2;
    assign in_comp[3] = s_data.comp3;

    // ---------------- multiplier issue ----------------
    // Product phase: step = {component, term}; the left operand index is
    // component xor term. Scale phase: one multiply per sum component.
    assign comp_k = scale_phase_reg ? step_reg[1:0] : step_reg[3:2];
    assign term_j = step_reg[1:0];

    always_comb begin
        mac_cmd.valid = (state_reg == ST_ISSUE);
        mac_cmd.tag   = comp_k;
        if (scale_phase_reg) begin
            mac_cmd.first = 1'b1;
            mac_cmd.last  = 1'b1;
            mac_cmd.neg   = 1'b0;
            mac_cmd.a     = sum_reg[comp_k];
            mac_cmd.b     = scale_reg;
        end else begin
            mac_cmd.first = (term_j == 2'd0);
            mac_cmd.last  = (term_j == 2'd3);
            mac_cmd.neg   = QMUL_NEG[step_reg];
            mac_cmd.a     = SUM_W'(prod_reg[comp_k ^ term_j]);
            mac_cmd.b     = q_reg[term_j];
        end
    end

    su2lpa_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .res     (mac_res)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        state_next       = state_reg;
        step_next        = step_reg;
        scale_phase_next = scale_phase_reg;
        q_next           = q_reg;
        end_term_next    = end_term_reg;
        end_sum_next     = end_sum_reg;
        prod_next        = prod_reg;
        sum_next         = sum_reg;
        res_next         = res_reg;
        scale_next       = scale_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;

        if (cfg_wr) begin
            scale_next = pwdata[COMP_W-1:0];
        end

        // capture finished components; products clip to 24 bits, scaled sums to 32
        if (mac_res.done) begin
            res_next[mac_res.tag] = scale_phase_reg ? sat_sum(mac_res.value)
                                                    : SUM_W'(sat_comp(mac_res.value));
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // conjugate: negate the Pauli part, most negative clips to max
                    q_next[0] = in_comp[0];
                    for (int i = 1; i < 4; i++) begin
                        if (!s_data.conjugate) begin
                            q_next[i] = in_comp[i];
                        end else if (in_comp[i] == COMP_MIN) begin
                            q_next[i] = COMP_MAX;
                        end else begin
                            q_next[i] = -in_comp[i];
                        end
                    end
                    end_term_next    = s_data.end_term;
                    end_sum_next     = s_data.end_sum;
                    scale_phase_next = 1'b0;
                    step_next        = '0;
                    state_next       = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                step_next = step_reg + 4'd1;
                if ((scale_phase_reg && step_reg == SCALE_LAST) || step_reg == MUL_LAST) begin
                    step_next  = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_res.done && mac_res.tag == 2'd3) begin
                    state_next = scale_phase_reg ? ST_EMIT : ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (end_term_reg || end_sum_reg) begin
                    // close the term: fold product into the sum, restart at identity
                    for (int i = 0; i < 4; i++) begin
                        sum_next[i]  = sat_sum(ACC_W'(sum_reg[i]) + ACC_W'(res_reg[i]));
                        prod_next[i] = (i == 0) ? IDENT : '0;
                    end
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        prod_next[i] = res_reg[i][COMP_W-1:0];
                    end
                end
                if (end_sum_reg) begin
                    scale_phase_next = 1'b1;
                    step_next        = '0;
                    state_next       = ST_ISSUE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                // hold here while the output register is still occupied
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_data_next.sum0     = res_reg[0];
                    m_data_next.sum1     = res_reg[1];
                    m_data_next.sum2     = res_reg[2];
                    m_data_next.sum3     = res_reg[3];
                    m_data_next.trace_re = sat_sum(ACC_W'(res_reg[0]) <<< 1);
                    for (int i = 0; i < 4; i++) begin
                        sum_next[i] = '0;
                    end
                    scale_phase_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            scale_phase_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
            scale_reg       <= SUM_SCALE_RST;
            for (int i = 0; i < 4; i++) begin
                prod_reg[i] <= (i == 0) ? IDENT : '0;
                sum_reg[i]  <= '0;
            end
        end else begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            scale_phase_reg <= scale_phase_next;
            m_valid_reg     <= m_valid_next;
            scale_reg       <= scale_next;
            prod_reg        <= prod_next;
            sum_reg         <= sum_next;
        end
        // payload
        q_reg        <= q_next;
        end_term_reg <= end_term_next;
        end_sum_reg  <= end_sum_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    `SU2LPA_ASSERT_NXT(a_accept_starts_issue, aclk, aresetn, s_valid && s_ready, (state_reg == ST_ISSUE) && (step_reg == 4'd0) && !scale_phase_reg, "core: accepted transaction did not start issue")
    `SU2LPA_ASSERT_IMP(a_final_result_in_drain, aclk, aresetn, mac_res.done && (mac_res.tag == 2'd3), state_reg == ST_DRAIN, "core: final component arrived outside drain")
    `SU2LPA_ASSERT_NXT(a_emit_clears_sum, aclk, aresetn, (state_reg == ST_EMIT) && (!m_valid_reg || m_ready), m_valid_reg && (sum_reg[0] == '0) && (state_reg == ST_IDLE), "core: emission did not clear the sum")

endmodule
